// ----- hdl/sha256_pkg.sv -----
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned PAD_LIMIT   = 56;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  typedef logic [31:0] word_t;

  function automatic word_t init_word(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } core_ctl_t;

endpackage

// ----- hdl/sha256_core.sv -----
`timescale 1ns / 1ps
// Compression unit: 16-entry schedule ring in four memory copies, one round per cycle.
// Block words are loaded through the word port during load_en, then start.
module sha256_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_en,
  input  logic [3:0]           load_addr,
  input  sha256_pkg::word_t    load_word,
  input  logic                 start,
  input  logic                 init_hash,
  input  logic [2:0]           hash_rd_idx,
  output sha256_pkg::word_t    hash_rd_word,
  output sha256_pkg::core_ctl_t ctl
);
  import sha256_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_ADD  = 2'd3;

  logic [1:0] state;
  logic [6:0] rnd;
  word_t h [8];
  word_t a, b, c, d, e, f, g, hh;

  // four ring copies give the four schedule taps
  word_t w0 [16];
  word_t w1 [16];
  word_t w9 [16];
  word_t w14 [16];
  word_t r0, r1, r9, r14;

  logic       wr_en;
  logic [3:0] wr_addr;
  word_t      wr_word;
  logic [5:0] ridx;
  logic [3:0] ra;

  word_t s0, s1, wnew, wcur, t1, t2;

  // rnd counts rounds; taps for round r+1 are read during round r
  assign ridx = rnd[5:0] + 6'd1;
  assign ra   = (state == S_FILL) ? 4'd0 : ridx[3:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      w0[wr_addr]  <= wr_word;
      w1[wr_addr]  <= wr_word;
      w9[wr_addr]  <= wr_word;
      w14[wr_addr] <= wr_word;
    end
    r0  <= w0[ra];
    r1  <= w1[ra + 4'd1];
    r9  <= w9[ra + 4'd9];
    r14 <= w14[ra + 4'd14];
  end

  always_comb begin
    s0   = {r1[6:0], r1[31:7]} ^ {r1[17:0], r1[31:18]} ^ (r1 >> 3);
    s1   = {r14[16:0], r14[31:17]} ^ {r14[18:0], r14[31:19]} ^ (r14 >> 10);
    wnew = r0 + s0 + r9 + s1;
    wcur = (rnd < 7'd16) ? r0 : wnew;
    t1 = hh + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
       + ((e & f) ^ (~e & g)) + ROUND_K[rnd[5:0]] + wcur;
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
       + ((a & b) ^ (a & c) ^ (b & c));
    wr_en   = load_en || (state == S_RUN && rnd >= 7'd16);
    wr_addr = load_en ? load_addr : rnd[3:0];
    wr_word = load_en ? load_word : wnew;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd   <= '0;
      for (int i = 0; i < 8; i++) h[i] <= init_word(3'(i));
    end else begin
      if (init_hash) begin
        for (int i = 0; i < 8; i++) h[i] <= init_word(3'(i));
      end
      unique case (state)
        S_IDLE: if (start) begin
          state <= S_FILL;
        end
        S_FILL: begin
          {a, b, c, d, e, f, g, hh} <= {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
          rnd   <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          hh <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd63) state <= S_ADD;
        end
        S_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c; h[3] <= h[3] + d;
          h[4] <= h[4] + e; h[5] <= h[5] + f; h[6] <= h[6] + g; h[7] <= h[7] + hh;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign hash_rd_word = h[hash_rd_idx];
  assign ctl.start = start;
  assign ctl.busy  = (state != S_IDLE);
  assign ctl.done  = (state == S_ADD);

endmodule

// ----- hdl/sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
// Byte requests are taken one per cycle while in the input state; the 64th byte of a
// block holds off requests while the block is read into the schedule memory and
// compressed (start, one setup read, 64 rounds, one hash add) in the single round unit.
// An end request runs one or two padded blocks, after the full block when its byte
// fills one; eight digest words follow, one per cycle taken.
// rst is synchronous: hash returns to the initial value, counts clear.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word, word_index, 5 zero bits
  output logic        m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_KICK = 3'd4;

  logic [2:0]  state;
  logic [5:0]  count;
  logic [60:0] msg_len;
  logic        fin, pad_blk, two_blk, full_blk;
  logic [2:0]  oidx;

  logic [7:0] buffer_mem [BLOCK_BYTES];
  logic [31:0] acc;
  word_t       acc_w;

  sha256_pkg::core_ctl_t ctl;
  logic       load_en, start, init_hash;
  word_t      hash_word;
  logic [63:0] bits;

  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IN);
  assign bits = {msg_len, 3'b000};

  always_ff @(posedge clk) begin
    if (acc_in && s_axis_tuser) buffer_mem[count] <= s_axis_tdata;
  end

  // padded byte at position pos of the one or two padding blocks
  function automatic logic [7:0] pad_at(input logic [6:0] pos, input logic [7:0] mem,
                                        input logic [5:0] n, input logic [63:0] len,
                                        input logic tb);
    logic [6:0] lim;
    logic [7:0] r;
    lim = tb ? 7'd120 : 7'd56;
    if (pos < {1'b0, n}) r = mem;
    else if (pos == {1'b0, n}) r = PAD_BYTE;
    else if (pos >= lim) r = len[8*(7 - (pos - lim)) +: 8];
    else r = 8'h00;
    return r;
  endfunction

  logic [3:0] lw_addr;

  // reading: step t issues address t, and the byte returns registered in mem_q in the next step
  logic [6:0] step;
  logic [5:0] baddr;
  logic [5:0] got;
  always_comb begin
    baddr = step[5:0];
    got   = 6'(step - 7'd1);
  end

  sha256_core u_core (
    .clk(clk), .rst(rst),
    .load_en(load_en), .load_addr(lw_addr), .load_word(acc_w),
    .start(start), .init_hash(init_hash),
    .hash_rd_idx(oidx), .hash_rd_word(hash_word), .ctl(ctl)
  );

  logic [7:0] rb2;
  logic [7:0] mem_q;
  always_ff @(posedge clk) mem_q <= buffer_mem[baddr];

  logic [6:0] gpos;
  assign gpos = {pad_blk, got};
  // a block filled by the end byte goes in raw; the padding block follows
  assign rb2 = (fin && !full_blk) ? pad_at(gpos, mem_q, count, bits, two_blk) : mem_q;
  assign load_en = (state == S_LOAD) && step != 7'd0 && got[1:0] == 2'd3;
  assign lw_addr = got[5:2];
  assign acc_w = {acc[23:0], rb2};
  assign start = (state == S_KICK);
  assign init_hash = (state == S_OUT) && m_axis_tready && oidx == 3'd7;

  always_ff @(posedge clk) begin
    if (load_en) acc <= acc_w;
    else if (state == S_LOAD) acc <= acc_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN; count <= '0; msg_len <= '0; fin <= 1'b0;
      pad_blk <= 1'b0; two_blk <= 1'b0; full_blk <= 1'b0; step <= '0; oidx <= '0;
    end else begin
      unique case (state)
        S_IN: if (acc_in) begin
          if (s_axis_tuser) begin
            count <= count + 6'd1;
            msg_len <= msg_len + 61'd1;
          end
          fin <= s_axis_tlast;
          pad_blk <= 1'b0;
          full_blk <= s_axis_tuser && count == 6'd63;
          two_blk <= (s_axis_tuser ? count + 6'd1 : count) >= 6'(PAD_LIMIT)
                     && !(s_axis_tuser && count == 6'd63);
          step <= '0;
          if ((s_axis_tuser && count == 6'd63) || s_axis_tlast) state <= S_LOAD;
        end
        S_LOAD: begin
          step <= step + 7'd1;
          if (step == 7'd64) state <= S_KICK;
        end
        S_KICK: state <= S_WAIT;
        S_WAIT: if (ctl.done) begin
          step <= '0;
          full_blk <= 1'b0;
          if (fin && full_blk) begin
            state <= S_LOAD;
          end else if (fin && two_blk && !pad_blk) begin
            pad_blk <= 1'b1; state <= S_LOAD;
          end else if (fin) begin
            state <= S_OUT; oidx <= '0;
          end else begin
            state <= S_IN;
          end
        end
        S_OUT: if (m_axis_tready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            state <= S_IN; count <= '0; msg_len <= '0; fin <= 1'b0;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {5'd0, oidx, hash_word};
  assign m_axis_tlast  = (oidx == 3'd7);

endmodule

// ----- hdl/sha256_checker.sv -----
`timescale 1ns / 1ps
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken during digest");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("last marker off");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
    (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("digest word skipped");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled word changed");
endmodule

bind sha256_stream_hasher sha256_checker u_chk (
  .clk(clk), .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
